/* src/smm_pkg.sv */
// Shared constants, types and helpers for the sparse matrix multiplier.
// No dependencies; every other file imports this package.
`timescale 1ns / 1ps

package smm_pkg;

   localparam int MAX_DIM      = 8;
   localparam int VALUE_BITS   = 16;
   localparam int CELLS        = MAX_DIM * MAX_DIM;
   localparam int ADDR_BITS    = (CELLS > 1) ? $clog2(CELLS) : 1;
   localparam int COORD_BITS   = 3;
   localparam int DIM_BITS     = 4;
   localparam int OUT_BITS     = 40;
   localparam int PROD_BITS    = 2 * VALUE_BITS;
   localparam int SUM_BITS     = ((PROD_BITS > OUT_BITS) ? PROD_BITS : OUT_BITS) + 1;
   localparam int REQ_BITS     = 2;
   localparam int STATUS_BITS  = 2;
   localparam int CSR_IDX_BITS = 2;

   localparam logic [REQ_BITS-1:0] REQ_LOAD_A   = 2'd0;
   localparam logic [REQ_BITS-1:0] REQ_LOAD_B   = 2'd1;
   localparam logic [REQ_BITS-1:0] REQ_MULTIPLY = 2'd2;

   localparam logic [STATUS_BITS-1:0] STATUS_ENTRY    = 2'd0;
   localparam logic [STATUS_BITS-1:0] STATUS_EMPTY    = 2'd1;
   localparam logic [STATUS_BITS-1:0] STATUS_INCOMPAT = 2'd2;

   localparam logic [CSR_IDX_BITS-1:0] CSR_A_ROWS = 2'd0;
   localparam logic [CSR_IDX_BITS-1:0] CSR_A_COLS = 2'd1;
   localparam logic [CSR_IDX_BITS-1:0] CSR_B_ROWS = 2'd2;
   localparam logic [CSR_IDX_BITS-1:0] CSR_B_COLS = 2'd3;

   localparam logic [DIM_BITS-1:0] DIM_RESET = DIM_BITS'(MAX_DIM);

   // One multiply-accumulate step travelling down the MAC pipeline.
   typedef struct packed {
      logic valid;
      logic first;      // first inner index of an output position
      logic last_step;  // last inner index of an output position
      logic pair_ok;    // both operands present (filled in by the store)
   } step_tag_type;

   function automatic logic [DIM_BITS-1:0] eff_dim(input logic [DIM_BITS-1:0] d);
      eff_dim = (d > DIM_BITS'(MAX_DIM)) ? DIM_BITS'(MAX_DIM) : d;
   endfunction

   function automatic logic [ADDR_BITS-1:0] cell_addr(input logic [COORD_BITS-1:0] row,
                                                      input logic [COORD_BITS-1:0] col);
      cell_addr = ADDR_BITS'(int'(row) * MAX_DIM + int'(col));
   endfunction

endpackage

/* src/smm_req_if.sv */
// Request channel: load A entry, load B entry or multiply.
// Depends on smm_pkg.
`timescale 1ns / 1ps

interface smm_req_if;
   import smm_pkg::*;

   logic                         valid;
   logic                         ready;
   logic [REQ_BITS-1:0]          req_type;
   logic [COORD_BITS-1:0]        entry_row;
   logic [COORD_BITS-1:0]        entry_col;
   logic signed [VALUE_BITS-1:0] entry_value;

   modport source (output valid, req_type, entry_row, entry_col, entry_value, input ready);
   modport sink   (input valid, req_type, entry_row, entry_col, entry_value, output ready);
endinterface

/* src/smm_rsp_if.sv */
// Result channel: one product entry or status item per handshake.
// Depends on smm_pkg.
`timescale 1ns / 1ps

interface smm_rsp_if;
   import smm_pkg::*;

   logic                       valid;
   logic                       ready;
   logic [COORD_BITS-1:0]      out_row;
   logic [COORD_BITS-1:0]      out_col;
   logic signed [OUT_BITS-1:0] out_value;
   logic [STATUS_BITS-1:0]     status;
   logic                       last;

   modport source (output valid, out_row, out_col, out_value, status, last, input ready);
   modport sink   (input valid, out_row, out_col, out_value, status, last, output ready);
endinterface

/* src/smm_csr_if.sv */
// Configuration write channel: register index and data.
// Depends on smm_pkg.
`timescale 1ns / 1ps

interface smm_csr_if;
   import smm_pkg::*;

   logic                    valid;
   logic                    ready;
   logic [CSR_IDX_BITS-1:0] index;
   logic [DIM_BITS-1:0]     data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

/* src/smm_store.sv */
// Entry stores for A and B: two memories, each with a write port and a
// registered read port, plus present bits in flip-flops. Depends on smm_pkg.
`timescale 1ns / 1ps

module smm_store (
   input  logic                                       clock,
   input  logic                                       reset,
   input  logic                                       wr_a,
   input  logic                                       wr_b,
   input  logic [smm_pkg::ADDR_BITS-1:0]              wr_addr,
   input  logic signed [smm_pkg::VALUE_BITS-1:0]      wr_data,
   input  logic                                       clear,
   input  logic [smm_pkg::ADDR_BITS-1:0]              rd_a_addr,
   input  logic [smm_pkg::ADDR_BITS-1:0]              rd_b_addr,
   input  smm_pkg::step_tag_type                      tag_in,
   output logic signed [smm_pkg::VALUE_BITS-1:0]      rd_a_data,
   output logic signed [smm_pkg::VALUE_BITS-1:0]      rd_b_data,
   output smm_pkg::step_tag_type                      tag_out
);
   import smm_pkg::*;

   logic signed [VALUE_BITS-1:0] a_store_ff [CELLS];
   logic signed [VALUE_BITS-1:0] b_store_ff [CELLS];
   logic [CELLS-1:0]             a_present_ff, a_present_in;
   logic [CELLS-1:0]             b_present_ff, b_present_in;
   logic signed [VALUE_BITS-1:0] rd_a_ff, rd_b_ff;
   step_tag_type                 tag_ff, tag_in_q;

   always_ff @(posedge clock) begin
      if (wr_a) begin
         a_store_ff[wr_addr] <= wr_data;
      end
      if (wr_b) begin
         b_store_ff[wr_addr] <= wr_data;
      end
      rd_a_ff <= a_store_ff[rd_a_addr];
      rd_b_ff <= b_store_ff[rd_b_addr];
   end

   always_comb begin
      a_present_in = a_present_ff;
      b_present_in = b_present_ff;
      if (clear) begin
         a_present_in = '0;
         b_present_in = '0;
      end else begin
         if (wr_a) begin
            a_present_in[wr_addr] = 1'b1;
         end
         if (wr_b) begin
            b_present_in[wr_addr] = 1'b1;
         end
      end
      tag_in_q         = tag_in;
      tag_in_q.pair_ok = a_present_ff[rd_a_addr] & b_present_ff[rd_b_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_present_ff <= '0;
         b_present_ff <= '0;
         tag_ff       <= '0;
      end else begin
         a_present_ff <= a_present_in;
         b_present_ff <= b_present_in;
         tag_ff       <= tag_in_q;
      end
   end

   assign rd_a_data = rd_a_ff;
   assign rd_b_data = rd_b_ff;
   assign tag_out   = tag_ff;

endmodule

/* src/smm_mac.sv */
// Shared multiply-accumulate unit: registered product, then saturating
// accumulate into a 40-bit sum. Depends on smm_pkg.
`timescale 1ns / 1ps

module smm_mac (
   input  logic                                   clock,
   input  logic                                   reset,
   input  smm_pkg::step_tag_type                  tag_in,
   input  logic signed [smm_pkg::VALUE_BITS-1:0]  a_data,
   input  logic signed [smm_pkg::VALUE_BITS-1:0]  b_data,
   output logic signed [smm_pkg::OUT_BITS-1:0]    acc,
   output logic                                   hit,
   output logic                                   done
);
   import smm_pkg::*;

   localparam logic signed [SUM_BITS-1:0] SAT_HI =
      {{(SUM_BITS-OUT_BITS+1){1'b0}}, {(OUT_BITS-1){1'b1}}};
   localparam logic signed [SUM_BITS-1:0] SAT_LO = ~SAT_HI;

   logic signed [PROD_BITS-1:0] prod_ff;
   step_tag_type                tag_ff;
   logic signed [OUT_BITS-1:0]  acc_ff, acc_in;
   logic                        hit_ff, hit_in;
   logic                        done_ff, done_in;
   logic signed [OUT_BITS-1:0]  base;
   logic signed [SUM_BITS-1:0]  sum;

   always_ff @(posedge clock) begin
      prod_ff <= PROD_BITS'(a_data * b_data);
   end

   always_comb begin
      base    = tag_ff.first ? '0 : acc_ff;
      sum     = SUM_BITS'(base) + SUM_BITS'(prod_ff);
      acc_in  = acc_ff;
      hit_in  = hit_ff;
      done_in = 1'b0;
      if (tag_ff.valid) begin
         done_in = tag_ff.last_step;
         if (tag_ff.pair_ok) begin
            hit_in = 1'b1;
            if (sum > SAT_HI) begin
               acc_in = OUT_BITS'(SAT_HI);
            end else if (sum < SAT_LO) begin
               acc_in = OUT_BITS'(SAT_LO);
            end else begin
               acc_in = OUT_BITS'(sum);
            end
         end else begin
            acc_in = base;
            hit_in = tag_ff.first ? 1'b0 : hit_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tag_ff  <= '0;
         hit_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         tag_ff  <= tag_in;
         hit_ff  <= hit_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      acc_ff <= acc_in;
   end

   assign acc  = acc_ff;
   assign hit  = hit_ff;
   assign done = done_ff;

endmodule

/* src/sparse_matrix_multiply.sv */
// Sparse matrix multiplier top level: request decode, configuration
// registers, position sequencer and result registers.
// Depends on smm_pkg, the channel interfaces, smm_store and smm_mac.
//
// Use: write a_rows, a_cols, b_rows, b_cols on the csr channel while idle
// (csr ready is always high). Load entries of A and B on the req channel,
// one item per cycle; loads outside the current dimensions are dropped.
// A multiply item makes the block busy (req ready low) until its last
// result sits in the output register. It yields one incompatible item,
// one empty item, or one item per populated product position in row-major
// order; the final one carries last. Both stores are cleared afterwards.
// Multiply sequence: for each output position the sequencer issues the
// inner steps in turn to both store read ports and the one shared MAC,
// waits in S_WAIT until the MAC reports the last step done, then places
// the result in S_PLACE; S_FINAL sends the final item.
// Results are registered and held while rsp ready is low; the sequencer
// waits when a new result finds both the output and holding registers full.
// Reset (synchronous, active high) sets all dimensions to 8, clears the
// present bits at once and returns the block to idle.
`timescale 1ns / 1ps

module sparse_matrix_multiply (
   input logic       clock,
   input logic       reset,
   smm_req_if.sink   req_ch,
   smm_rsp_if.source rsp_ch,
   smm_csr_if.sink   csr_ch
);
   import smm_pkg::*;

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_ISSUE = 3'd1;
   localparam logic [2:0] S_WAIT  = 3'd2;
   localparam logic [2:0] S_PLACE = 3'd3;
   localparam logic [2:0] S_FINAL = 3'd4;

   logic [DIM_BITS-1:0] a_rows_ff, a_cols_ff, b_rows_ff, b_cols_ff;
   logic [DIM_BITS-1:0] nr, ni, nk, a_cols_eff, b_rows_eff;

   logic [2:0]            state_ff, state_in;
   logic [COORD_BITS-1:0] i_ff, i_in, j_ff, j_in, k_ff, k_in;
   logic                  incompat_ff, incompat_in;

   logic                       pend_valid_ff, pend_valid_in;
   logic [COORD_BITS-1:0]      pend_row_ff, pend_row_in, pend_col_ff, pend_col_in;
   logic signed [OUT_BITS-1:0] pend_value_ff, pend_value_in;

   logic                       rsp_valid_ff, rsp_valid_in;
   logic [COORD_BITS-1:0]      rsp_row_ff, rsp_row_in, rsp_col_ff, rsp_col_in;
   logic signed [OUT_BITS-1:0] rsp_value_ff, rsp_value_in;
   logic [STATUS_BITS-1:0]     rsp_status_ff, rsp_status_in;
   logic                       rsp_last_ff, rsp_last_in;

   logic req_fire, out_free, last_j, last_k, last_i;
   logic load_ok, wr_a, wr_b, clear;

   step_tag_type                 issue_tag, mem_tag;
   logic signed [VALUE_BITS-1:0] a_data, b_data;
   logic signed [OUT_BITS-1:0]   mac_acc;
   logic                         mac_hit, mac_done;

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         a_rows_ff <= DIM_RESET;
         a_cols_ff <= DIM_RESET;
         b_rows_ff <= DIM_RESET;
         b_cols_ff <= DIM_RESET;
      end else if (csr_ch.valid) begin
         case (csr_ch.index)
            CSR_A_ROWS: a_rows_ff <= csr_ch.data;
            CSR_A_COLS: a_cols_ff <= csr_ch.data;
            CSR_B_ROWS: b_rows_ff <= csr_ch.data;
            CSR_B_COLS: b_cols_ff <= csr_ch.data;
            default: ;
         endcase
      end
   end
   assign csr_ch.ready = 1'b1;

   assign a_cols_eff = eff_dim(a_cols_ff);
   assign b_rows_eff = eff_dim(b_rows_ff);
   assign nr = eff_dim(a_rows_ff);
   assign nk = eff_dim(b_cols_ff);
   assign ni = (a_cols_eff < b_rows_eff) ? a_cols_eff : b_rows_eff;

   assign req_ch.ready = (state_ff == S_IDLE);
   assign req_fire     = req_ch.valid & req_ch.ready;
   assign out_free     = ~rsp_valid_ff | rsp_ch.ready;

   assign last_j = (DIM_BITS'(j_ff) + 1'b1) == ni;
   assign last_k = (DIM_BITS'(k_ff) + 1'b1) == nk;
   assign last_i = (DIM_BITS'(i_ff) + 1'b1) == nr;

   // Load decode
   always_comb begin
      load_ok = 1'b0;
      case (req_ch.req_type)
         REQ_LOAD_A: load_ok = (DIM_BITS'(req_ch.entry_row) < nr) &&
                               (DIM_BITS'(req_ch.entry_col) < a_cols_eff);
         REQ_LOAD_B: load_ok = (DIM_BITS'(req_ch.entry_row) < b_rows_eff) &&
                               (DIM_BITS'(req_ch.entry_col) < nk);
         default:    load_ok = 1'b0;
      endcase
   end
   assign wr_a = req_fire && load_ok && (req_ch.req_type == REQ_LOAD_A);
   assign wr_b = req_fire && load_ok && (req_ch.req_type == REQ_LOAD_B);

   always_comb begin
      issue_tag           = '0;
      issue_tag.valid     = (state_ff == S_ISSUE);
      issue_tag.first     = (j_ff == '0);
      issue_tag.last_step = last_j;
   end

   smm_store u_store (
      .clock     (clock),
      .reset     (reset),
      .wr_a      (wr_a),
      .wr_b      (wr_b),
      .wr_addr   (cell_addr(req_ch.entry_row, req_ch.entry_col)),
      .wr_data   (req_ch.entry_value),
      .clear     (clear),
      .rd_a_addr (cell_addr(i_ff, j_ff)),
      .rd_b_addr (cell_addr(j_ff, k_ff)),
      .tag_in    (issue_tag),
      .rd_a_data (a_data),
      .rd_b_data (b_data),
      .tag_out   (mem_tag)
   );

   smm_mac u_mac (
      .clock  (clock),
      .reset  (reset),
      .tag_in (mem_tag),
      .a_data (a_data),
      .b_data (b_data),
      .acc    (mac_acc),
      .hit    (mac_hit),
      .done   (mac_done)
   );

   // Sequencer
   always_comb begin
      state_in      = state_ff;
      i_in          = i_ff;
      j_in          = j_ff;
      k_in          = k_ff;
      incompat_in   = incompat_ff;
      pend_valid_in = pend_valid_ff;
      pend_row_in   = pend_row_ff;
      pend_col_in   = pend_col_ff;
      pend_value_in = pend_value_ff;
      rsp_valid_in  = rsp_valid_ff & ~rsp_ch.ready;
      rsp_row_in    = rsp_row_ff;
      rsp_col_in    = rsp_col_ff;
      rsp_value_in  = rsp_value_ff;
      rsp_status_in = rsp_status_ff;
      rsp_last_in   = rsp_last_ff;
      clear         = 1'b0;

      case (state_ff)
         S_IDLE: begin
            if (req_fire && req_ch.req_type == REQ_MULTIPLY) begin
               i_in          = '0;
               j_in          = '0;
               k_in          = '0;
               pend_valid_in = 1'b0;
               incompat_in   = (a_cols_ff != b_rows_ff);
               if (a_cols_ff != b_rows_ff || nr == '0 || ni == '0 || nk == '0) begin
                  state_in = S_FINAL;
               end else begin
                  state_in = S_ISSUE;
               end
            end
         end
         S_ISSUE: begin
            j_in = j_ff + 1'b1;
            if (last_j) begin
               j_in     = '0;
               state_in = S_WAIT;
            end
         end
         S_WAIT: begin
            if (mac_done) begin
               state_in = S_PLACE;
            end
         end
         S_PLACE: begin
            if (!mac_hit || !pend_valid_ff || out_free) begin
               if (mac_hit) begin
                  if (pend_valid_ff) begin
                     rsp_valid_in  = 1'b1;
                     rsp_row_in    = pend_row_ff;
                     rsp_col_in    = pend_col_ff;
                     rsp_value_in  = pend_value_ff;
                     rsp_status_in = STATUS_ENTRY;
                     rsp_last_in   = 1'b0;
                  end
                  pend_valid_in = 1'b1;
                  pend_row_in   = i_ff;
                  pend_col_in   = k_ff;
                  pend_value_in = mac_acc;
               end
               state_in = S_ISSUE;
               if (last_k) begin
                  k_in = '0;
                  i_in = i_ff + 1'b1;
                  if (last_i) begin
                     state_in = S_FINAL;
                  end
               end else begin
                  k_in = k_ff + 1'b1;
               end
            end
         end
         S_FINAL: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_last_in  = 1'b1;
               if (incompat_ff) begin
                  rsp_row_in    = '0;
                  rsp_col_in    = '0;
                  rsp_value_in  = '0;
                  rsp_status_in = STATUS_INCOMPAT;
               end else if (pend_valid_ff) begin
                  rsp_row_in    = pend_row_ff;
                  rsp_col_in    = pend_col_ff;
                  rsp_value_in  = pend_value_ff;
                  rsp_status_in = STATUS_ENTRY;
               end else begin
                  rsp_row_in    = '0;
                  rsp_col_in    = '0;
                  rsp_value_in  = '0;
                  rsp_status_in = STATUS_EMPTY;
               end
               pend_valid_in = 1'b0;
               clear         = 1'b1;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         i_ff          <= '0;
         j_ff          <= '0;
         k_ff          <= '0;
         incompat_ff   <= 1'b0;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         i_ff          <= i_in;
         j_ff          <= j_in;
         k_ff          <= k_in;
         incompat_ff   <= incompat_in;
         pend_valid_ff <= pend_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pend_row_ff   <= pend_row_in;
      pend_col_ff   <= pend_col_in;
      pend_value_ff <= pend_value_in;
      rsp_row_ff    <= rsp_row_in;
      rsp_col_ff    <= rsp_col_in;
      rsp_value_ff  <= rsp_value_in;
      rsp_status_ff <= rsp_status_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign rsp_ch.valid     = rsp_valid_ff;
   assign rsp_ch.out_row   = rsp_row_ff;
   assign rsp_ch.out_col   = rsp_col_ff;
   assign rsp_ch.out_value = rsp_value_ff;
   assign rsp_ch.status    = rsp_status_ff;
   assign rsp_ch.last      = rsp_last_ff;

endmodule
